// ----- sv/c2cs_pkg.sv -----
package c2cs_pkg;

  // Datapath widths.
  localparam int SumW  = 66;  // sum of three squared 33 bit magnitudes
  localparam int RemW  = 67;  // square root remainder
  localparam int SqW   = 34;  // square root result, unsigned Q18.16
  localparam int QW    = 33;  // quotient bits kept by the divider
  localparam int CInW  = 35;  // signed CORDIC operand
  localparam int CordW = 64;  // CORDIC working vector
  localparam int AngW  = 33;  // CORDIC angle accumulator, Q3.29
  localparam int CordSteps = 30;
  localparam int NormTop   = 58;  // larger operand is scaled into [2^58, 2^59)

  // Stage counts of the pipelined units.
  localparam int SqLat   = SqW;
  localparam int DivLat  = 1 + QW;
  localparam int CordLat = 3 + CordSteps + 1;

  localparam logic signed [AngW-1:0] PiQ     = 33'sd1686629713;
  localparam logic signed [AngW-1:0] HalfPiQ = 33'sd843314857;

  typedef enum logic [1:0] {
    CfgCx   = 2'd0,
    CfgCy   = 2'd1,
    CfgCz   = 2'd2,
    CfgRmin = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [30:0] tolerance;
  } in_t;

  typedef struct packed {
    logic signed [31:0] radial_num;
    logic        [30:0] polar_angle;
    logic signed [31:0] azimuth_angle;
    logic               inside_res;
    logic               radius_zero;
  } out_t;

  // Arctangent of 2^-i in Q3.29.
  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0:  v = 33'sd421657428;
      1:  v = 33'sd248918915;
      2:  v = 33'sd131521918;
      3:  v = 33'sd66762579;
      4:  v = 33'sd33510843;
      5:  v = 33'sd16771758;
      6:  v = 33'sd8387925;
      7:  v = 33'sd4194219;
      8:  v = 33'sd2097141;
      9:  v = 33'sd1048575;
      default: v = AngW'(64'sd1 <<< (29 - i));
    endcase
    return v;
  endfunction

endpackage

// ----- sv/c2cs_sqrt.sv -----
module c2cs_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [c2cs_pkg::SumW-1:0] sum_i,
  output logic [c2cs_pkg::SqW-1:0]  root_o
);
  import c2cs_pkg::*;

  logic [RemW-1:0] rem_q  [SqW];
  logic [SqW-1:0]  root_q [SqW];

  // One result bit per stage, most significant first, by the remainder method.
  for (genvar g = 0; g < SqW; g++) begin : g_stage
    localparam int B = SqW - 1 - g;
    logic [RemW-1:0] rem_in;
    logic [RemW-1:0] trial;
    logic [SqW-1:0]  root_in;

    if (g == 0) begin : g_first
      assign rem_in  = RemW'(sum_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // (root + 2^B)^2 - root^2, the root having no bits at or below B.
    assign trial = (RemW'(root_in) << (B + 1)) | (RemW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[g]  <= rem_in - trial;
          root_q[g] <= root_in | (SqW'(1) << B);
        end else begin
          rem_q[g]  <= rem_in;
          root_q[g] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SqW-1];

endmodule

// ----- sv/c2cs_div.sv -----
module c2cs_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [c2cs_pkg::SqW-1:0] r_i,
  input  logic [30:0]             rmin_i,
  output logic [c2cs_pkg::QW-1:0]  quot_o,
  output logic                    ovf_o
);
  import c2cs_pkg::*;

  // Stage zero: the part of rmin * 2^31 above bit 32 must stay below r.
  logic [SqW-1:0] r_q   [DivLat];
  logic [SqW-1:0] rem_q [DivLat];
  logic [QW-1:0]  q_q   [DivLat];
  logic           ovf_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r_i;
      rem_q[0] <= SqW'(rmin_i[30:2]);
      q_q[0]   <= '0;
      ovf_q[0] <= SqW'(rmin_i[30:2]) >= r_i;
    end
  end

  // Restoring steps, one quotient bit each, numerator bits 32 down to 0.
  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int Bt = QW - 1 - g;
    logic          nb;
    logic [SqW:0]  sh;

    if (Bt == 32) begin : g_b1
      assign nb = rmin_i[1];
    end else if (Bt == 31) begin : g_b0
      assign nb = rmin_i[0];
    end else begin : g_bz
      assign nb = 1'b0;
    end

    assign sh = {rem_q[g], nb};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g+1]   <= r_q[g];
        ovf_q[g+1] <= ovf_q[g];
        if (sh >= {1'b0, r_q[g]}) begin
          rem_q[g+1] <= SqW'(sh - {1'b0, r_q[g]});
          q_q[g+1]   <= {q_q[g][QW-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= SqW'(sh);
          q_q[g+1]   <= {q_q[g][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = q_q[DivLat-1];
  assign ovf_o  = ovf_q[DivLat-1];

endmodule

// ----- sv/c2cs_cordic.sv -----
module c2cs_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [c2cs_pkg::CInW-1:0] x_i,
  input  logic signed [c2cs_pkg::CInW-1:0] y_i,
  output logic signed [31:0]              angle_o
);
  import c2cs_pkg::*;

  localparam int NSt = CordLat - 1;

  logic signed [CordW-1:0] x_q    [NSt];
  logic signed [CordW-1:0] y_q    [NSt];
  logic signed [AngW-1:0]  acc_q  [NSt];
  logic                    spec_q [NSt];
  logic signed [AngW-1:0]  sval_q [NSt];
  logic signed [CInW-1:0]  x0_q, y0_q;
  logic [5:0]              p0_q;
  logic signed [31:0]      angle_q;

  // Stage zero: exact axis cases and the top bit of the larger magnitude.
  logic [CInW-1:0]        ax, ay, m;
  logic [5:0]             p;
  logic                   spec;
  logic signed [AngW-1:0] sval;

  always_comb begin
    ax = x_i[CInW-1] ? CInW'(-x_i) : CInW'(x_i);
    ay = y_i[CInW-1] ? CInW'(-y_i) : CInW'(y_i);
    m  = (ax > ay) ? ax : ay;
    p  = '0;
    for (int b = 0; b < CInW; b++) begin
      if (m[b]) p = 6'(b);
    end
    spec = 1'b0;
    sval = '0;
    if (y_i == '0) begin
      spec = 1'b1;
      sval = x_i[CInW-1] ? PiQ : '0;
    end else if (x_i == '0) begin
      spec = 1'b1;
      sval = y_i[CInW-1] ? -HalfPiQ : HalfPiQ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q      <= x_i;
      y0_q      <= y_i;
      p0_q      <= p;
      spec_q[0] <= spec;
      sval_q[0] <= sval;
      x_q[0]    <= '0;
      y_q[0]    <= '0;
      acc_q[0]  <= '0;
    end
  end

  // Stage one: scale both operands by the same power of two.
  logic [5:0] sh;
  assign sh = 6'(NormTop) - p0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1]    <= CordW'(x0_q) <<< sh;
      y_q[1]    <= CordW'(y0_q) <<< sh;
      acc_q[1]  <= '0;
      spec_q[1] <= spec_q[0];
      sval_q[1] <= sval_q[0];
    end
  end

  // Stage two: a left half-plane vector is turned by a quarter turn.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec_q[2] <= spec_q[1];
      sval_q[2] <= sval_q[1];
      if (x_q[1] < 0) begin
        if (y_q[1] >= 0) begin
          x_q[2]   <= y_q[1];
          y_q[2]   <= -x_q[1];
          acc_q[2] <= HalfPiQ;
        end else begin
          x_q[2]   <= -y_q[1];
          y_q[2]   <= x_q[1];
          acc_q[2] <= -HalfPiQ;
        end
      end else begin
        x_q[2]   <= x_q[1];
        y_q[2]   <= y_q[1];
        acc_q[2] <= '0;
      end
    end
  end

  // Vectoring steps, one micro-rotation per stage.
  for (genvar g = 0; g < CordSteps; g++) begin : g_step
    logic signed [CordW-1:0] xs, ys;
    assign xs = x_q[g+2] >>> g;
    assign ys = y_q[g+2] >>> g;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        spec_q[g+3] <= spec_q[g+2];
        sval_q[g+3] <= sval_q[g+2];
        if (y_q[g+2] >= 0) begin
          x_q[g+3]   <= x_q[g+2] + ys;
          y_q[g+3]   <= y_q[g+2] - xs;
          acc_q[g+3] <= acc_q[g+2] + atan_tab(g);
        end else begin
          x_q[g+3]   <= x_q[g+2] - ys;
          y_q[g+3]   <= y_q[g+2] + xs;
          acc_q[g+3] <= acc_q[g+2] - atan_tab(g);
        end
      end
    end
  end

  // Last stage: axis value or clamped sum.
  logic signed [AngW-1:0] afin;
  always_comb begin
    afin = acc_q[NSt-1];
    if (afin > PiQ) afin = PiQ;
    if (afin < -PiQ) afin = -PiQ;
    if (spec_q[NSt-1]) afin = sval_q[NSt-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= afin[31:0];
    end
  end

  assign angle_o = angle_q;

endmodule

// ----- sv/cartesian_to_compact_spherical.sv -----
// Channel   Direction  Handshake                  Beat
// in        input      in_valid_i / in_stall_o    c2cs_pkg::in_t   (kind, pos, tolerance)
// out       output     out_valid_o / out_stall_i  c2cs_pkg::out_t  (radial, angles, flags)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One point enters per cycle while the output is not stalled.
// Each result passes the subtract, square and sum stages, the 34 stage square root, then
// the 34 stage divider and CORDIC units, which run side by side, and the output stage.
// Reset clears the valid bits and loads the register reset values; no clearing pass.
// A stalled output beat freezes the whole pipeline, so nothing is lost or repeated.
module cartesian_to_compact_spherical (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  c2cs_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output c2cs_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);
  import c2cs_pkg::*;

  localparam int SqOut   = 2 + SqLat;
  localparam int PathEnd = SqOut + CordLat;
  localparam int OutSt   = PathEnd + 1;
  localparam int NSt     = OutSt + 1;

  // Configuration registers.
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rmin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      rmin_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgCx:   cx_q   <= cfg_data_i;
        CfgCy:   cy_q   <= cfg_data_i;
        CfgCz:   cz_q   <= cfg_data_i;
        CfgRmin: rmin_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits.
  logic           en;
  logic [NSt-1:0] v_q;

  assign en          = !(v_q[NSt-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSt-2:0], in_valid_i};
    end
  end

  // Stage zero: offsets from the center, carried to the angle units.
  logic signed [32:0] dx_q  [SqOut+1];
  logic signed [32:0] dy_q  [SqOut+1];
  logic signed [32:0] dz_q  [SqOut+1];
  logic [30:0]        tol_q [SqOut+1];
  logic               kind_q [PathEnd+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0]   <= {in_data_i.pos_x[31], in_data_i.pos_x} - {cx_q[31], cx_q};
      dy_q[0]   <= {in_data_i.pos_y[31], in_data_i.pos_y} - {cy_q[31], cy_q};
      dz_q[0]   <= {in_data_i.pos_z[31], in_data_i.pos_z} - {cz_q[31], cz_q};
      tol_q[0]  <= in_data_i.tolerance;
      kind_q[0] <= in_data_i.kind;
      for (int k = 1; k <= SqOut; k++) begin
        dx_q[k]  <= dx_q[k-1];
        dy_q[k]  <= dy_q[k-1];
        dz_q[k]  <= dz_q[k-1];
        tol_q[k] <= tol_q[k-1];
      end
      for (int k = 1; k <= PathEnd; k++) begin
        kind_q[k] <= kind_q[k-1];
      end
    end
  end

  // Stage one: squared magnitudes.
  logic [32:0]     adx, ady, adz;
  logic [SumW-2:0] sx_q, sy_q, sz_q;

  assign adx = dx_q[0][32] ? 33'(-dx_q[0]) : 33'(dx_q[0]);
  assign ady = dy_q[0][32] ? 33'(-dy_q[0]) : 33'(dy_q[0]);
  assign adz = dz_q[0][32] ? 33'(-dz_q[0]) : 33'(dz_q[0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= (SumW-1)'(adx * adx);
      sy_q <= (SumW-1)'(ady * ady);
      sz_q <= (SumW-1)'(adz * adz);
    end
  end

  // Stage two: cylindrical and full squared radii.
  logic [SumW-1:0] sxy_q, sall_q;
  logic [SumW-1:0] sxy;

  assign sxy = SumW'(sx_q) + SumW'(sy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxy_q  <= sxy;
      sall_q <= sxy + SumW'(sz_q);
    end
  end

  // Square roots of both sums.
  logic [SqW-1:0] r, rho;

  c2cs_sqrt u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sall_q),
    .root_o (r)
  );

  c2cs_sqrt u_sqrt_rho (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sxy_q),
    .root_o (rho)
  );

  // Radial quotient rmin * 2^31 / r.
  logic [QW-1:0] quot;
  logic          ovf;

  c2cs_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .r_i    (r),
    .rmin_i (rmin_q),
    .quot_o (quot),
    .ovf_o  (ovf)
  );

  // Polar and azimuth angles.
  logic signed [31:0] pol_ang, az_ang;

  c2cs_cordic u_cordic_pol (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     ({{(CInW-33){dz_q[SqOut][32]}}, dz_q[SqOut]}),
    .y_i     ({1'b0, rho}),
    .angle_o (pol_ang)
  );

  c2cs_cordic u_cordic_az (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     ({{(CInW-33){dx_q[SqOut][32]}}, dx_q[SqOut]}),
    .y_i     ({{(CInW-33){dy_q[SqOut][32]}}, dy_q[SqOut]}),
    .angle_o (az_ang)
  );

  // Membership test: product first, then the compare, then delay to the end.
  logic [SqW+31:0] prod_q;
  logic            zr_q  [PathEnd-SqOut];
  logic            ins_q [PathEnd-SqOut-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= r * (32'd1073741824 + 32'(tol_q[SqOut]));
      zr_q[0]  <= (r == '0);
      ins_q[0] <= (SqW+32)'({rmin_q, 30'd0}) <= prod_q;
      for (int k = 1; k < PathEnd - SqOut; k++) begin
        zr_q[k] <= zr_q[k-1];
      end
      for (int k = 1; k < PathEnd - SqOut - 1; k++) begin
        ins_q[k] <= ins_q[k-1];
      end
    end
  end

  // Output stage: radial value with saturation, angle limits, flags.
  logic signed [34:0] rd;
  logic signed [31:0] radial;
  logic               zero_f;
  out_t               out_q;

  assign zero_f = zr_q[PathEnd-SqOut-1];
  assign rd     = 35'sd1073741824 - $signed({2'b00, quot});

  always_comb begin
    if (zero_f || ovf || rd < -35'sd2147483648) begin
      radial = 32'sh80000000;
    end else begin
      radial = rd[31:0];
    end
    if (kind_q[PathEnd]) radial = -32'sd1073741824;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.radial_num    <= radial;
      out_q.polar_angle   <= pol_ang[31] ? 31'd0 : pol_ang[30:0];
      out_q.azimuth_angle <= az_ang;
      out_q.inside_res    <= ins_q[PathEnd-SqOut-2] && !zero_f;
      out_q.radius_zero   <= zero_f;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import c2cs_pkg::*;

  localparam int IdleLimit  = 3000;
  localparam int DrainWait  = 120;
  localparam int HoldCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Local copy of the register file.
  longint center_x = 0, center_y = 0, center_z = 0;
  longint inner_radius = 65536;

  in_t points_to_send[$];
  out_t coords_expected[$];
  int mismatches = 0;
  int beats_in = 0, beats_out = 0, cfg_writes = 0;
  int idle_cycles = 0;
  int max_in_gap = 15, max_out_gap = 15;
  int hold_requests = 0;
  int in_wait = 0;
  int out_wait = 0, hold_left = 0, holds_seen = 0;

  longint atan_q29[30] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1
  };

  always #5 clk = ~clk;

  cartesian_to_compact_spherical u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Bit-serial integer square root of a wide sum.
  function automatic logic [33:0] int_sqrt(input logic [67:0] s);
    logic [33:0] res;
    logic [33:0] c;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (34'd1 << b);
      if ((68'(c) * 68'(c)) <= s) res = c;
    end
    return res;
  endfunction

  // CORDIC arctangent of y/x in Q3.29, with exact answers on the axes.
  function automatic longint cordic_atan2(input longint x, input longint y);
    longint acc, t, xs, ys, mx, my;
    int k;
    acc = 0;
    k = 0;
    if (y == 0) return (x >= 0) ? 0 : longint'(PiQ);
    if (x == 0) return (y > 0) ? longint'(HalfPiQ) : -longint'(HalfPiQ);
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    if (my > mx) mx = my;
    while (mx < (64'sd1 <<< 58)) begin
      mx = mx <<< 1;
      k++;
    end
    x = x <<< k;
    y = y <<< k;
    // Bring a left half-plane vector into the right half-plane first.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = HalfPiQ;
      end else begin
        t = x; x = -y; y = t; acc = -longint'(HalfPiQ);
      end
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += atan_q29[i];
      end else begin
        x = x - ys; y = y + xs; acc -= atan_q29[i];
      end
    end
    if (acc > PiQ) acc = PiQ;
    if (acc < -longint'(PiQ)) acc = -longint'(PiQ);
    return acc;
  endfunction

  // Expected spherical coordinates of one point under the current registers.
  function automatic out_t spherical_coords(input in_t p);
    out_t o;
    longint dx, dy, dz, radial, polar;
    logic [32:0] ax, ay, az;
    logic [67:0] sxy, sall, lhs, rhs;
    logic [33:0] r, rho;
    logic [63:0] quot;
    dx = longint'(p.pos_x) - center_x;
    dy = longint'(p.pos_y) - center_y;
    dz = longint'(p.pos_z) - center_z;
    ax = 33'((dx < 0) ? -dx : dx);
    ay = 33'((dy < 0) ? -dy : dy);
    az = 33'((dz < 0) ? -dz : dz);
    sxy = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
    sall = sxy + 68'(az) * 68'(az);
    r = int_sqrt(sall);
    rho = int_sqrt(sxy);
    o = '0;
    o.radius_zero = (r == 0);
    if (r == 0) begin
      radial = -(64'sd1 <<< 31);
    end else begin
      quot = (64'(inner_radius) << 31) / 64'(r);
      radial = (64'sd1 <<< 30) - longint'(quot);
      if (radial < -(64'sd1 <<< 31)) radial = -(64'sd1 <<< 31);
      lhs = 68'(inner_radius) << 30;
      rhs = 68'(r) * ((68'd1 << 30) + 68'(p.tolerance));
      o.inside_res = (lhs <= rhs);
    end
    if (p.kind) radial = -(64'sd1 <<< 30);
    polar = cordic_atan2(dz, longint'(rho));
    if (polar < 0) polar = 0;
    o.radial_num = 32'(radial);
    o.polar_angle = 31'(polar);
    o.azimuth_angle = 32'(cordic_atan2(dx, dy));
    return o;
  endfunction

  // Driver: offers queued points, with a random gap before each one.
  always @(posedge clk) begin
    logic took;
    logic nv;
    in_t nd;
    took = in_valid && !in_stall;
    nv = in_valid;
    nd = in_data;
    if (took) begin
      coords_expected.push_back(spherical_coords(in_data));
      void'(points_to_send.pop_front());
      beats_in++;
    end
    if (!in_valid || took) begin
      nv = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
      end else if (points_to_send.size() > 0) begin
        nv = 1'b1;
        nd = points_to_send[0];
        in_wait = $urandom_range(0, max_in_gap);
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Monitor: checks each output beat and drives the stall.
  always @(posedge clk) begin
    out_t want;
    logic nstall;
    if (out_valid && !out_stall) begin
      beats_out++;
      if (coords_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %p", out_data);
      end else begin
        want = coords_expected.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
      out_wait = $urandom_range(0, max_out_gap);
    end
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = HoldCycles;
    end
    nstall = (out_wait > 0) || (hold_left > 0);
    if (out_wait > 0) out_wait--;
    if (hold_left > 0) hold_left--;
    out_stall <= nstall;
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CfgCx:   center_x = longint'(signed'(value));
      CfgCy:   center_y = longint'(signed'(value));
      CfgCz:   center_z = longint'(signed'(value));
      CfgRmin: inner_radius = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (points_to_send.size() == 0 && coords_expected.size() == 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic in_t make_point(input logic kind, input longint x, input longint y,
                                     input longint z, input logic [30:0] tol);
    in_t p;
    p.kind = kind;
    p.pos_x = 32'(x);
    p.pos_y = 32'(y);
    p.pos_z = 32'(z);
    p.tolerance = tol;
    return p;
  endfunction

  // Random points: mostly near the center, some on axes, some anywhere.
  task automatic queue_random(input int n);
    in_t p;
    int sel;
    longint span;
    for (int i = 0; i < n; i++) begin
      p.kind = ($urandom_range(0, 3) == 0);
      p.tolerance = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 30));
      sel = $urandom_range(0, 9);
      span = longint'(1) << $urandom_range(0, 31);
      p.pos_x = 32'(center_x + longint'($urandom_range(0, 2 * 32'(span))) - span);
      p.pos_y = 32'(center_y + longint'($urandom_range(0, 2 * 32'(span))) - span);
      p.pos_z = 32'(center_z + longint'($urandom_range(0, 2 * 32'(span))) - span);
      if (sel <= 2) begin
        p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
      end else if (sel == 3) begin
        p.pos_x = 32'(center_x); p.pos_y = 32'(center_y);
      end else if (sel == 4) begin
        if ($urandom_range(0, 1)) p.pos_y = 32'(center_y);
        else p.pos_x = 32'(center_x);
      end else if (sel == 5 && $urandom_range(0, 3) == 0) begin
        p.pos_x = 32'(center_x); p.pos_y = 32'(center_y); p.pos_z = 32'(center_z);
      end
      points_to_send.push_back(p);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed points under the reset registers.
    points_to_send.push_back(make_point(0, 0, 0, 0, 0));
    points_to_send.push_back(make_point(1, 0, 0, 0, 31'h4000_0000));
    points_to_send.push_back(make_point(0, 0, 0, 65536, 0));
    points_to_send.push_back(make_point(0, 0, 0, -65536, 0));
    points_to_send.push_back(make_point(0, 65536, 0, 0, 0));
    points_to_send.push_back(make_point(0, -65536, 0, 0, 0));
    points_to_send.push_back(make_point(0, 0, 65536, 0, 0));
    points_to_send.push_back(make_point(0, 0, -65536, 0, 0));
    points_to_send.push_back(make_point(0, 65535, 0, 0, 0));
    points_to_send.push_back(make_point(0, 65535, 0, 0, 31'h4000_0000));
    points_to_send.push_back(make_point(0, 1, 0, 0, 0));
    points_to_send.push_back(make_point(1, -1, -1, -1, 31'h7fff_ffff));
    points_to_send.push_back(make_point(0, -2147483648, -2147483648, -2147483648, 0));
    points_to_send.push_back(make_point(0, 2147483647, 2147483647, 2147483647, 31'h7fff_ffff));
    points_to_send.push_back(make_point(0, -2147483648, 0, 2147483647, 12345));
    points_to_send.push_back(make_point(1, 3, -7, 0, 0));
    points_to_send.push_back(make_point(0, -5, 1, 0, 0));
    points_to_send.push_back(make_point(0, -5, -1, 0, 0));
    wait_drained();

    // Extreme center and smallest radius; receiver holds off meanwhile.
    write_reg(CfgCx, 32'h8000_0000);
    write_reg(CfgCy, 32'h7fff_ffff);
    write_reg(CfgCz, 32'h8000_0000);
    write_reg(CfgRmin, 32'd1);
    @(negedge clk);
    hold_requests++;
    queue_random(200);
    wait_drained();

    // Largest radius, opposite extreme center, no idling on either side.
    write_reg(CfgCx, 32'h7fff_ffff);
    write_reg(CfgCy, 32'h8000_0000);
    write_reg(CfgCz, 32'h7fff_ffff);
    write_reg(CfgRmin, 32'h7fff_ffff);
    max_in_gap = 0;
    max_out_gap = 0;
    queue_random(200);
    wait_drained();

    // Moderate random settings with random idling.
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CfgCx, $urandom);
      write_reg(CfgCy, $urandom_range(0, 1 << 20));
      write_reg(CfgCz, -$urandom_range(0, 1 << 20));
      write_reg(CfgRmin, $urandom_range(1, 1 << 22));
      max_in_gap = ph ? 3 : 15;
      max_out_gap = ph ? 15 : 3;
      queue_random(200);
      wait_drained();
    end

    $display("Covered %0d points, %0d results, %0d register writes over five settings.",
             beats_in, beats_out, cfg_writes);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
